FILE: sv/bpci_pkg.sv
// Shared types and constants for the balanced Peano curve index block.
// No dependencies; every module of the block imports this package.
package bpci_pkg;

    localparam int COORD_W    = 48;
    localparam int WIDTH_W    = 47;
    localparam int LEVEL_W    = 5;
    localparam int CONST_W    = 32;
    localparam int DIV_CNT_W  = 6;
    localparam int CFG_IDX_W  = 1;

    localparam logic [LEVEL_W-1:0]   MAX_LEVELS    = LEVEL_W'(30);
    localparam logic [CONST_W-1:0]   INV_SQRT3_Q32 = 32'd2479700525;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST      = DIV_CNT_W'(COORD_W - 1);

    localparam logic [WIDTH_W-1:0] WRAP_WIDTH_RESET  = 47'd1546188226560;
    localparam logic [LEVEL_W-1:0] LEVEL_COUNT_RESET = LEVEL_W'(30);

    localparam logic [CFG_IDX_W-1:0] REG_WRAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX,
        ST_MULT,
        ST_STEP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic fix;
        logic mult;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] levels;
    } status_t;

endpackage

FILE: sv/balanced_peano_curve_index_top.sv
// Sequence: once start is taken, the remainder for the wrap over the 48 dividend bits, then a multiply
// and a digit step for each of L levels, L being level_count capped at 30; then done pulses.
// A new word is taken only after done, once busy is low again; results cannot be stalled.
// Reset: rst_n asynchronous, active low; wrap_width returns to 360.0 and level_count to 30.
// Top level: joins bpci_ctrl and bpci_datapath; depends on bpci_pkg.
module balanced_peano_curve_index_top
    import bpci_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    output logic                        done,
    input  logic signed [COORD_W-1:0]   coord_x,
    input  logic signed [COORD_W-1:0]   coord_y,
    output logic [COORD_W-1:0]          curve_index,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [WIDTH_W-1:0]          cfg_data
);

    cmd_t    cmd;
    status_t status;

    bpci_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    bpci_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .status      (status),
        .curve_index (curve_index)
    );

endmodule

FILE: sv/bpci_ctrl.sv
// Sequencer for the balanced Peano curve index block: state machine and step counters.
// Depends on bpci_pkg; drives bpci_datapath through cmd_t and reads status_t.
module bpci_ctrl
    import bpci_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done
);

    state_t                 state_reg, state_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [LEVEL_W-1:0]     lvl_reg, lvl_next;
    logic                   last_level;

    assign last_level = (lvl_reg == status.levels - LEVEL_W'(1));

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        lvl_next     = lvl_reg;
        case (state_reg)
            ST_IDLE:
            begin
                div_cnt_next = '0;
                lvl_next     = '0;
                if (start)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                if (status.levels == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                lvl_next = lvl_reg + LEVEL_W'(1);
                if (last_level)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MULT;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_DIV:  cmd.div_step = 1'b1;
            ST_FIX:  cmd.fix      = 1'b1;
            ST_MULT: cmd.mult     = 1'b1;
            ST_STEP: cmd.step     = 1'b1;
            ST_DONE: done         = 1'b1;
            default: busy         = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
            lvl_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            lvl_reg     <= lvl_next;
        end
    end

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy still high after result word");

    a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && state_reg == ST_DIV))
        else $error("accepted word did not enter the remainder phase");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> (lvl_reg < status.levels))
        else $error("level step beyond configured level count");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_cnt_reg <= DIV_LAST))
        else $error("remainder counter overran");

endmodule

FILE: sv/bpci_datapath.sv
// Datapath: configuration registers, bit-serial wrap remainders and the per-level digit step.
// Depends on bpci_pkg; sequenced by bpci_ctrl through cmd_t.
module bpci_datapath
    import bpci_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [WIDTH_W-1:0]          cfg_data,
    input  cmd_t                        cmd,
    input  logic signed [COORD_W-1:0]   coord_x,
    input  logic signed [COORD_W-1:0]   coord_y,
    output status_t                     status,
    output logic [COORD_W-1:0]          curve_index
);

    logic [WIDTH_W-1:0]         wrap_width_reg;
    logic [LEVEL_W-1:0]         level_count_reg;

    logic [COORD_W-1:0]         dvd_x_reg, dvd_y_reg;
    logic [WIDTH_W-1:0]         rem_x_reg, rem_y_reg;
    logic                       neg_x_reg, neg_y_reg;
    logic                       gtw_x_reg, gtw_y_reg;
    logic [WIDTH_W-1:0]         x_reg, y_reg, h_reg;
    logic [2*CONST_W-1:0]       pl_reg;
    logic [WIDTH_W-1:0]         ph_reg;
    logic [COORD_W-1:0]         idx_reg;

    logic [COORD_W-1:0]         raw_x, raw_y, mag_x, mag_y, dec_x, dec_y;
    logic                       neg_x, neg_y, gtw_x, gtw_y;
    logic [COORD_W-1:0]         try_x, try_y;
    logic [WIDTH_W-1:0]         rem_x_next, rem_y_next;
    logic [WIDTH_W-1:0]         fix_x, fix_y;
    logic                       w_zero;
    logic [2*CONST_W:0]         rnd_sum;
    logic [WIDTH_W-1:0]         part;
    logic [COORD_W-1:0]         part2;
    logic [WIDTH_W-1:0]         x_next, y_next;
    logic [COORD_W-1:0]         idx_next;

    assign status.levels = (level_count_reg > MAX_LEVELS) ? MAX_LEVELS : level_count_reg;
    assign curve_index   = idx_reg;
    assign w_zero        = (wrap_width_reg == '0);

    assign raw_x = $unsigned(coord_x);
    assign raw_y = $unsigned(coord_y);
    assign neg_x = raw_x[COORD_W-1];
    assign neg_y = raw_y[COORD_W-1];
    assign mag_x = ~raw_x + COORD_W'(1);
    assign mag_y = ~raw_y + COORD_W'(1);
    assign dec_x = raw_x - COORD_W'(1);
    assign dec_y = raw_y - COORD_W'(1);
    assign gtw_x = !neg_x && (raw_x > {1'b0, wrap_width_reg});
    assign gtw_y = !neg_y && (raw_y > {1'b0, wrap_width_reg});

    // restoring remainder, one dividend bit a cycle
    assign try_x = {rem_x_reg, dvd_x_reg[COORD_W-1]};
    assign try_y = {rem_y_reg, dvd_y_reg[COORD_W-1]};
    assign rem_x_next = (try_x >= {1'b0, wrap_width_reg})
                        ? WIDTH_W'(try_x - {1'b0, wrap_width_reg}) : WIDTH_W'(try_x);
    assign rem_y_next = (try_y >= {1'b0, wrap_width_reg})
                        ? WIDTH_W'(try_y - {1'b0, wrap_width_reg}) : WIDTH_W'(try_y);

    always_comb
    begin
        if (w_zero)
            fix_x = '0;
        else if (neg_x_reg)
            fix_x = (rem_x_reg == '0) ? '0 : wrap_width_reg - rem_x_reg;
        else if (gtw_x_reg)
            fix_x = rem_x_reg + WIDTH_W'(1);
        else
            fix_x = x_reg;

        if (w_zero)
            fix_y = '0;
        else if (neg_y_reg)
            fix_y = (rem_y_reg == '0) ? '0 : wrap_width_reg - rem_y_reg;
        else if (gtw_y_reg)
            fix_y = rem_y_reg + WIDTH_W'(1);
        else
            fix_y = y_reg;
    end

    // part = round(h / sqrt3) from the two registered partial products
    assign rnd_sum = {1'b0, pl_reg} + (2*CONST_W+1)'(64'd1 << (CONST_W - 1));
    assign part    = ph_reg + WIDTH_W'(rnd_sum[2*CONST_W:CONST_W]);
    assign part2   = {part, 1'b0};

    always_comb
    begin
        if ({1'b0, x_reg} < {1'b0, part})
        begin
            x_next   = y_reg;
            y_next   = x_reg;
            idx_next = (idx_reg << 1) + idx_reg;
        end
        else if ({1'b0, x_reg} < part2)
        begin
            x_next   = (y_reg > h_reg) ? '0 : h_reg - y_reg;
            y_next   = x_reg - part;
            idx_next = (idx_reg << 1) + idx_reg + COORD_W'(1);
        end
        else
        begin
            x_next   = y_reg;
            y_next   = WIDTH_W'({1'b0, x_reg} - part2);
            idx_next = (idx_reg << 1) + idx_reg + COORD_W'(2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_width_reg  <= WRAP_WIDTH_RESET;
            level_count_reg <= LEVEL_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WRAP_WIDTH:  wrap_width_reg  <= cfg_data;
                REG_LEVEL_COUNT: level_count_reg <= cfg_data[LEVEL_W-1:0];
                default:         level_count_reg <= level_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dvd_x_reg <= neg_x ? mag_x : (gtw_x ? dec_x : raw_x);
            dvd_y_reg <= neg_y ? mag_y : (gtw_y ? dec_y : raw_y);
            rem_x_reg <= '0;
            rem_y_reg <= '0;
            neg_x_reg <= neg_x;
            neg_y_reg <= neg_y;
            gtw_x_reg <= gtw_x;
            gtw_y_reg <= gtw_y;
            x_reg     <= raw_x[WIDTH_W-1:0];
            y_reg     <= raw_y[WIDTH_W-1:0];
            h_reg     <= wrap_width_reg;
            idx_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            dvd_x_reg <= dvd_x_reg << 1;
            dvd_y_reg <= dvd_y_reg << 1;
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
        end
        if (cmd.fix)
        begin
            x_reg <= fix_x;
            y_reg <= fix_y;
        end
        if (cmd.mult)
        begin
            pl_reg <= h_reg[CONST_W-1:0] * INV_SQRT3_Q32;
            ph_reg <= WIDTH_W'(h_reg[WIDTH_W-1:CONST_W] * INV_SQRT3_Q32);
        end
        if (cmd.step)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            h_reg   <= part;
            idx_reg <= idx_next;
        end
    end

    a_part_below_h: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (part <= h_reg))
        else $error("cell part exceeds cell height");

    a_rem_below_w: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fix && !w_zero) |-> (rem_x_reg < wrap_width_reg && rem_y_reg < wrap_width_reg))
        else $error("remainder not below wrap width");

    a_fix_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fix |=> (x_reg <= wrap_width_reg && y_reg <= wrap_width_reg))
        else $error("wrapped coordinate outside the cell");

endmodule
